FILE: design/afr_pkg.sv
// Shared types and constants for the API frame receiver.
// No dependencies; used by the interfaces, the deframer and the top level.
package afr_pkg;

    // Payload store depth; bytes at or beyond it are not forwarded.
    localparam int unsigned BUFFER_DEPTH = 64;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned INDEX_W = 6;

    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);
    localparam logic [LEN_W-1:0] POS_MAX   = {LEN_W{1'b1}};

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_BASE   = 8'hFF;
    localparam logic [7:0] TICKS_MAX  = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    // Input word kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] data_index;
        logic               frame_end;
        logic               frame_good;
        logic [LEN_W-1:0]   frame_length;
        logic               timed_out;
    } t_result;

endpackage

FILE: design/afr_if.sv
// Channel interfaces of the API frame receiver: input words, result words and
// the configuration write channel. Depends on afr_pkg.
interface afr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface afr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          data_valid;
    logic [7:0]                    data_byte;
    logic [afr_pkg::INDEX_W-1:0]   data_index;
    logic                          frame_end;
    logic                          frame_good;
    logic [afr_pkg::LEN_W-1:0]     frame_length;
    logic                          timed_out;

    modport source (output valid, output data_valid, output data_byte, output data_index,
                    output frame_end, output frame_good, output frame_length,
                    output timed_out, input ready);
    modport sink (input valid, input data_valid, input data_byte, input data_index,
                  input frame_end, input frame_good, input frame_length,
                  input timed_out, output ready);
endinterface

interface afr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] timeout_ticks;

    modport source (output valid, output timeout_ticks, input ready);
    modport sink (input valid, input timeout_ticks, output ready);
endinterface

FILE: design/afr_deframer.sv
// Frame state machine of the API frame receiver: holds the deframing state and
// computes one result per word. Depends on afr_pkg.
module afr_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_kind,
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_timeout_ticks,
    output afr_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_MSB,
        PH_LSB,
        PH_DATA
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [7:0]                 r_length_high, n_length_high;
    logic [afr_pkg::LEN_W-1:0]  r_declared_length, n_declared_length;
    logic [afr_pkg::LEN_W-1:0]  r_bytes_remaining, n_bytes_remaining;
    logic [afr_pkg::LEN_W-1:0]  r_byte_position, n_byte_position;
    logic [7:0]                 r_running_sum, n_running_sum;
    logic [7:0]                 r_idle_ticks, n_idle_ticks;
    logic [7:0]                 w_ticks_inc;
    afr_pkg::t_result           w_result;

    assign w_ticks_inc = (r_idle_ticks != afr_pkg::TICKS_MAX) ? r_idle_ticks + 8'd1
                                                               : r_idle_ticks;

    always_comb begin
        n_phase           = r_phase;
        n_length_high     = r_length_high;
        n_declared_length = r_declared_length;
        n_bytes_remaining = r_bytes_remaining;
        n_byte_position   = r_byte_position;
        n_running_sum     = r_running_sum;
        n_idle_ticks      = r_idle_ticks;
        w_result          = '0;

        if (i_kind == afr_pkg::KIND_TICK) begin
            if (r_phase != PH_HUNT) begin
                n_idle_ticks = w_ticks_inc;
                if (w_ticks_inc >= i_timeout_ticks) begin
                    n_phase            = PH_HUNT;
                    n_idle_ticks       = '0;
                    w_result.timed_out = 1'b1;
                end
            end
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == afr_pkg::START_BYTE) begin
                        n_phase      = PH_MSB;
                        n_idle_ticks = '0;
                    end
                end
                PH_MSB: begin
                    n_length_high = i_rx_byte;
                    n_idle_ticks  = '0;
                    n_phase       = PH_LSB;
                end
                PH_LSB: begin
                    n_declared_length = {r_length_high, i_rx_byte};
                    n_bytes_remaining = {r_length_high, i_rx_byte};
                    n_byte_position   = '0;
                    n_running_sum     = '0;
                    n_idle_ticks      = '0;
                    n_phase           = PH_DATA;
                end
                PH_DATA: begin
                    n_idle_ticks = '0;
                    if (r_bytes_remaining == '0) begin
                        // Checksum byte closes the frame.
                        w_result.frame_end    = 1'b1;
                        w_result.frame_good   =
                            (i_rx_byte == (afr_pkg::SUM_BASE - r_running_sum)) &&
                            (r_declared_length <= afr_pkg::DEPTH_LEN);
                        w_result.frame_length = r_declared_length;
                        n_phase               = PH_HUNT;
                    end else begin
                        if (r_byte_position < afr_pkg::DEPTH_LEN) begin
                            w_result.data_valid = 1'b1;
                            w_result.data_byte  = i_rx_byte;
                            w_result.data_index = r_byte_position[afr_pkg::INDEX_W-1:0];
                        end
                        n_running_sum     = r_running_sum + i_rx_byte;
                        n_bytes_remaining = r_bytes_remaining - afr_pkg::LEN_W'(1);
                        if (r_byte_position != afr_pkg::POS_MAX) begin
                            n_byte_position = r_byte_position + afr_pkg::LEN_W'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    assign o_result = w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HUNT;
            r_length_high     <= '0;
            r_declared_length <= '0;
            r_bytes_remaining <= '0;
            r_byte_position   <= '0;
            r_running_sum     <= '0;
            r_idle_ticks      <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_length_high     <= n_length_high;
            r_declared_length <= n_declared_length;
            r_bytes_remaining <= n_bytes_remaining;
            r_byte_position   <= n_byte_position;
            r_running_sum     <= n_running_sum;
            r_idle_ticks      <= n_idle_ticks;
        end
    end

endmodule

FILE: design/api_frame_receiver.sv
// API frame receiver: two-stage pipeline, input word register then result
// register. A result word is registered in the result stage when its input word
// moves on from the input stage, which a waiting result can hold back; one word is
// accepted every cycle while results are taken. Depends on afr_pkg, afr_if and
// afr_deframer. Synchronous active-low reset returns to start-byte hunt, empties
// both stages and restores the timeout register to ten ticks.
module api_frame_receiver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    afr_in_if.sink         i_in,
    afr_out_if.source      o_out,
    afr_cfg_if.sink        i_cfg
);

    // Input stage register. The stage holds one accepted word until the
    // deframer consumes it into the result stage.
    logic             r_in_valid;
    logic             r_in_kind;
    logic [7:0]       r_in_byte;

    // Result stage register.
    logic             r_out_valid;
    afr_pkg::t_result r_result;

    logic [7:0]       r_timeout_ticks;

    logic             w_advance;
    logic             w_in_accept;
    afr_pkg::t_result w_result;

    // A word moves from the input stage into the result stage whenever the
    // result stage is empty or its word is being taken this cycle. The input
    // stage in turn takes a new word when it is empty or is moving on. A result
    // left waiting downstream holds the word behind it in the input stage, and
    // the input channel stalls while both stages are full and that result waits.
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    // The timeout register can always take a write.
    assign i_cfg.ready = 1'b1;

    afr_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_kind          (r_in_kind),
        .i_rx_byte       (r_in_byte),
        .i_timeout_ticks (r_timeout_ticks),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_timeout_ticks <= afr_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_timeout_ticks <= i_cfg.timeout_ticks;
            end
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_kind <= i_in.kind;
            r_in_byte <= i_in.rx_byte;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_valid   = r_result.data_valid;
    assign o_out.data_byte    = r_result.data_byte;
    assign o_out.data_index   = r_result.data_index;
    assign o_out.frame_end    = r_result.frame_end;
    assign o_out.frame_good   = r_result.frame_good;
    assign o_out.frame_length = r_result.frame_length;
    assign o_out.timed_out    = r_result.timed_out;

endmodule

FILE: tb/sv/tb_api_frame_receiver.sv
// Self-checking testbench for the API frame receiver: directed frames, then random
// frame traffic with stalls on both channels, checked word by word against a predictor.
// Depends on afr_pkg, the channel interfaces in afr_if and the api_frame_receiver top.
module tb_api_frame_receiver;

    // A stretch this long with no word moving on any channel means the block hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_WORDS   = 950;
    // The last part of the random traffic runs with both sides always willing.
    localparam int unsigned QUIET_AFTER    = 800;
    localparam int unsigned MAX_REPORTS    = 50;

    // Deframer phases of the predictor.
    typedef enum logic [1:0] {
        RX_HUNT,
        RX_LEN_HI,
        RX_LEN_LO,
        RX_PAYLOAD
    } t_rx_phase;

    logic i_clk;
    logic i_rst_n;

    afr_in_if  in_ch ();
    afr_out_if out_ch ();
    afr_cfg_if cfg_ch ();

    api_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state, a private copy of what the deframer holds.
    t_rx_phase                 rx_phase;
    logic [7:0]                model_timeout;
    logic [7:0]                len_hi;
    logic [afr_pkg::LEN_W-1:0] frame_len;
    logic [afr_pkg::LEN_W-1:0] bytes_left;
    logic [afr_pkg::LEN_W-1:0] payload_pos;
    logic [7:0]                payload_sum;
    logic [7:0]                idle_count;

    // Result words predicted for accepted input words, oldest first.
    afr_pkg::t_result due_results[$];

    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned words_sent;
    // Timeout as the stimulus side believes it is programmed.
    int unsigned cur_timeout;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // One step of the deframer: consumes an input word, returns the result word it
    // causes. Every input word causes exactly one result word, all zero when the
    // word changes nothing visible.
    function automatic afr_pkg::t_result deframe_step(input logic kind, input logic [7:0] b);
        afr_pkg::t_result r;
        logic    sum_ok;
        logic    fits;
        r = '0;
        if (kind == afr_pkg::KIND_TICK) begin
            // Ticks only count while inside a frame; the count saturates.
            if (rx_phase != RX_HUNT) begin
                if (idle_count < afr_pkg::TICKS_MAX) begin
                    idle_count = idle_count + 8'd1;
                end
                // A zero timeout behaves like one, since the count is at least one here.
                if (idle_count >= model_timeout) begin
                    rx_phase   = RX_HUNT;
                    idle_count = '0;
                    r.timed_out = 1'b1;
                end
            end
        end else begin
            case (rx_phase)
                RX_HUNT: begin
                    if (b == afr_pkg::START_BYTE) begin
                        rx_phase   = RX_LEN_HI;
                        idle_count = '0;
                    end
                end
                RX_LEN_HI: begin
                    len_hi     = b;
                    idle_count = '0;
                    rx_phase   = RX_LEN_LO;
                end
                RX_LEN_LO: begin
                    frame_len   = {len_hi, b};
                    bytes_left  = {len_hi, b};
                    payload_pos = '0;
                    payload_sum = '0;
                    idle_count  = '0;
                    rx_phase    = RX_PAYLOAD;
                end
                default: begin
                    // A start byte in here is just another payload or checksum byte.
                    idle_count = '0;
                    if (bytes_left == '0) begin
                        sum_ok = (b == afr_pkg::SUM_BASE - payload_sum);
                        fits   = (frame_len <= afr_pkg::DEPTH_LEN);
                        r.frame_end    = 1'b1;
                        r.frame_good   = sum_ok && fits;
                        r.frame_length = frame_len;
                        rx_phase       = RX_HUNT;
                    end else begin
                        // Bytes past the buffer are summed but not forwarded.
                        if (payload_pos < afr_pkg::DEPTH_LEN) begin
                            r.data_valid = 1'b1;
                            r.data_byte  = b;
                            r.data_index = payload_pos[afr_pkg::INDEX_W-1:0];
                        end
                        payload_sum = payload_sum + b;
                        bytes_left  = bytes_left - 1'b1;
                        if (payload_pos < afr_pkg::POS_MAX) begin
                            payload_pos = payload_pos + 1'b1;
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [afr_pkg::LEN_W-1:0] got,
                                   input logic [afr_pkg::LEN_W-1:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        end
        mismatch_count++;
    endtask

    // Compares the result word on the output channel with the oldest prediction.
    task automatic check_result();
        afr_pkg::t_result want;
        if (due_results.size() == 0) begin
            report_mismatch("result word with nothing expected", '0, '0);
        end else begin
            want = due_results.pop_front();
            if (out_ch.data_valid !== want.data_valid)
                report_mismatch("data_valid", out_ch.data_valid, want.data_valid);
            if (out_ch.data_byte !== want.data_byte)
                report_mismatch("data_byte", out_ch.data_byte, want.data_byte);
            if (out_ch.data_index !== want.data_index)
                report_mismatch("data_index", out_ch.data_index, want.data_index);
            if (out_ch.frame_end !== want.frame_end)
                report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
            if (out_ch.frame_good !== want.frame_good)
                report_mismatch("frame_good", out_ch.frame_good, want.frame_good);
            if (out_ch.frame_length !== want.frame_length)
                report_mismatch("frame_length", out_ch.frame_length, want.frame_length);
            if (out_ch.timed_out !== want.timed_out)
                report_mismatch("timed_out", out_ch.timed_out, want.timed_out);
        end
    endtask

    // The one place where handshakes are observed. Values read here are those from
    // before the edge, so results, configuration and input words are seen in a
    // fixed order: a result word is checked before the input word of the same edge
    // adds its prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_phase      <= RX_HUNT;
            model_timeout <= afr_pkg::TIMEOUT_RESET;
            len_hi        <= '0;
            frame_len     <= '0;
            bytes_left    <= '0;
            payload_pos   <= '0;
            payload_sum   <= '0;
            idle_count    <= '0;
            due_results.delete();
            stuck_cycles  <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                model_timeout = cfg_ch.timeout_ticks;
            end
            if (in_ch.valid && in_ch.ready) begin
                due_results.push_back(deframe_step(in_ch.kind, in_ch.rx_byte));
            end
            if ((out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (in_ch.valid && in_ch.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles = stuck_cycles + 1;
            end
        end
    end

    // Receiver side: ready drops in random bursts; no new burst starts when quiet.
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run if the block stops moving words altogether.
    initial begin
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Sends one input word. Called at a falling edge, returns at the falling edge
    // after the word was taken, with valid still high so back-to-back words need
    // no extra assignment.
    task automatic send_word(input logic kind, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_word(afr_pkg::KIND_TICK, 8'($urandom));
    endtask

    // Stops the sender until every predicted result word has come back. With one
    // result per input word, the block is idle once nothing is due.
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (due_results.size() != 0);
    endtask

    // Writes the timeout register; only called while the block is idle.
    task automatic write_timeout(input logic [7:0] value);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.timeout_ticks <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_timeout = value;
    endtask

    function automatic int unsigned ticks_to_abort();
        return (cur_timeout == 0) ? 1 : cur_timeout;
    endfunction

    // Between frame bytes, sometimes a few ticks that stay short of the timeout,
    // and now and then exactly one tick short of it.
    task automatic maybe_ticks(input bit enable);
        int unsigned limit;
        int unsigned count;
        limit = ticks_to_abort() - 1;
        if (enable && limit > 0 && $urandom_range(0, 3) == 0) begin
            if (limit <= 20 && $urandom_range(0, 3) == 0) begin
                count = limit;
            end else begin
                count = $urandom_range(1, (limit < 3) ? limit : 3);
            end
            send_ticks(count);
        end
    endtask

    // Sends a frame of len random payload bytes. With cut below zero the frame is
    // sent whole, ending in a checksum that is right unless bad_sum asks otherwise.
    // Otherwise only the first cut+1 bytes of start, length and payload go out, and
    // the frame is then left to time out.
    task automatic send_frame(input int unsigned len, input bit bad_sum, input bit with_ticks,
                              input int cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        logic [7:0] b;
        int unsigned n;
        sum = '0;
        frame_bytes.push_back(afr_pkg::START_BYTE);
        frame_bytes.push_back(8'(len >> 8));
        frame_bytes.push_back(8'(len));
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            frame_bytes.push_back(b);
        end
        n = (cut < 0) ? frame_bytes.size() : cut + 1;
        for (int unsigned i = 0; i < n; i++) begin
            if (i > 0) maybe_ticks(with_ticks);
            send_word(afr_pkg::KIND_BYTE, frame_bytes[i]);
        end
        if (cut < 0) begin
            maybe_ticks(with_ticks);
            b = afr_pkg::SUM_BASE - sum;
            if (bad_sum) b = b ^ (8'h01 << $urandom_range(0, 7));
            send_word(afr_pkg::KIND_BYTE, b);
        end else begin
            send_ticks(ticks_to_abort());
        end
    endtask

    // While hunting, bytes other than the start byte and all ticks are ignored.
    task automatic test_hunt_noise();
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_TICK, 8'hFF);
        send_word(afr_pkg::KIND_BYTE, 8'hFF);
        send_word(afr_pkg::KIND_BYTE, 8'h7F);
    endtask

    // A two-byte frame whose payload holds a start byte and the top byte value,
    // then a one-byte frame with a wrong checksum.
    task automatic test_short_frames();
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_BYTE, 8'h02);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_BYTE, 8'hFF);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::SUM_BASE - (afr_pkg::START_BYTE + 8'hFF));
        send_frame(1, 1'b1, 1'b0, -1);
    endtask

    // Empty frames: the next byte is the checksum, good only when it is all ones.
    task automatic test_zero_length();
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::SUM_BASE);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
        send_word(afr_pkg::KIND_BYTE, 8'h00);
    endtask

    // A zero timeout aborts on the first idle tick, here with the largest length.
    task automatic test_timeout_extremes();
        wait_results_drained();
        write_timeout(8'h00);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_TICK, 8'h00);
        send_word(afr_pkg::KIND_BYTE, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_BYTE, 8'hFF);
        send_word(afr_pkg::KIND_BYTE, 8'hFF);
        send_word(afr_pkg::KIND_TICK, afr_pkg::START_BYTE);
        send_word(afr_pkg::KIND_TICK, 8'h55);
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 82) return $urandom_range(63, 66);
        if (r < 88) return $urandom_range(67, 72);
        return $urandom_range(9, 40);
    endfunction

    // Random traffic in phases. Each phase programs a new timeout while idle and
    // then sends mostly well-formed frames, with some bad checksums, abandoned
    // frames that must time out, and noise while hunting.
    task automatic test_random_traffic();
        int unsigned phase_no;
        int unsigned segments;
        int unsigned r;
        int unsigned len;
        logic [7:0] b;
        phase_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            wait_results_drained();
            case (phase_no)
                0: write_timeout(8'hFF);
                1: write_timeout(8'h00);
                2: write_timeout(8'h01);
                3: write_timeout(8'h02);
                default: begin
                    if ($urandom_range(0, 3) == 0) write_timeout(8'($urandom));
                    else write_timeout(8'($urandom_range(2, 12)));
                end
            endcase
            segments = (phase_no == 0) ? 4 : 8;
            for (int unsigned s = 0; s < segments && words_sent < RANDOM_WORDS; s++) begin
                quiet = (words_sent >= QUIET_AFTER);
                r = $urandom_range(0, 99);
                len = pick_length();
                if (r < 60) begin
                    send_frame(len, 1'b0, 1'b1, -1);
                end else if (r < 72) begin
                    send_frame(len, 1'b1, 1'b1, -1);
                end else if (r < 82) begin
                    // Cut anywhere from right after the start byte to just before
                    // the checksum.
                    send_frame(len, 1'b0, 1'b1, $urandom_range(0, len + 2));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_word(afr_pkg::KIND_TICK, 8'($urandom));
                        end else begin
                            b = 8'($urandom);
                            if (b == afr_pkg::START_BYTE) b = b ^ 8'h01;
                            send_word(afr_pkg::KIND_BYTE, b);
                        end
                    end
                end
            end
            phase_no++;
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = afr_pkg::KIND_BYTE;
        in_ch.rx_byte        = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.timeout_ticks = '0;
        mismatch_count       = 0;
        stuck_cycles         = 0;
        words_sent           = 0;
        cur_timeout          = afr_pkg::TIMEOUT_RESET;
        quiet                = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_hunt_noise();
        test_short_frames();
        test_zero_length();
        test_timeout_extremes();
        words_sent = 0;
        test_random_traffic();

        // Everything is sent: wait for the last result words, then let the clock run on
        // so that a stray extra word would still be caught.
        quiet = 1'b1;
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
